@@ sv/dpr_pkg.sv @@
// dpr_pkg: widths, register map, reset values and shared types for the
// disparity reprojection pipeline; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpr_pkg;

    // input field widths
    localparam int DISP_BITS  = 8;
    localparam int COORD_BITS = 12;

    // calibration register widths
    localparam int F_W  = 20;
    localparam int B_W  = 21;
    localparam int NB_W = B_W + 1;
    localparam int C_W  = 16;
    localparam int Z_W  = 24;

    // result widths and quotient width
    localparam int XY_W = 25;
    localparam int Q_W  = 25;

    // divider organization: quotient bits resolved per stage
    localparam int DIV_STEPS  = 5;
    localparam int DIV_STAGES = Q_W / DIV_STEPS;

    // datapath widths
    localparam int CS_W   = COORD_BITS + 4;
    localparam int OFF_W  = ((CS_W > C_W) ? CS_W : C_W) + 1;
    localparam int PZ_W   = NB_W + F_W + 1;
    localparam int PXY_W  = NB_W + OFF_W;
    localparam int P_W    = (PZ_W > PXY_W) ? PZ_W : PXY_W;
    localparam int NUM_W  = P_W - 4;
    localparam int HI_W   = NUM_W - Q_W;
    localparam int CMP_W  = (HI_W > DISP_BITS) ? HI_W : DISP_BITS;

    // pipeline depth: multiply, magnitude, divider stages, output
    localparam int NSTG = DIV_STAGES + 3;

    // lane positions
    localparam int LANE_Z = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANES  = 3;

    // apb port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_FOCAL    = 3'd0,
        REG_BASELINE = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_Z_MIN    = 3'd4,
        REG_Z_MAX    = 3'd5
    } reg_idx_t;

    // reset calibration
    localparam logic [F_W-1:0]         FOCAL_RST    = 20'd27628;
    localparam logic signed [B_W-1:0]  BASELINE_RST = -21'sd59841;
    localparam logic signed [NB_W-1:0] NEG_BASE_RST = 22'sd59841;
    localparam logic [C_W-1:0]         CENTER_X_RST = 16'd10138;
    localparam logic [C_W-1:0]         CENTER_Y_RST = 16'd7918;
    localparam logic [Z_W-1:0]         Z_MIN_RST    = 24'd100000;
    localparam logic [Z_W-1:0]         Z_MAX_RST    = 24'd1000000;

    // saturation limits on the quotient magnitude
    localparam logic [Q_W-1:0] XY_POS_LIM = 25'h0FFFFFF;
    localparam logic [Q_W-1:0] XY_NEG_LIM = 25'h1000000;

    typedef struct packed {
        logic [F_W-1:0]         focal;
        logic signed [B_W-1:0]  baseline;
        logic signed [NB_W-1:0] neg_baseline;
        logic [C_W-1:0]         center_x;
        logic [C_W-1:0]         center_y;
        logic [Z_W-1:0]         z_min;
        logic [Z_W-1:0]         z_max;
    } cfg_t;

    // one division lane: sign, overflow, partial remainder, dividend/quotient bits
    typedef struct packed {
        logic                 neg;
        logic                 ovf;
        logic [DISP_BITS-1:0] rem;
        logic [Q_W-1:0]       bits;
    } lane_t;

    typedef struct packed {
        logic [DISP_BITS-1:0] d;
        lane_t [LANES-1:0]    lane;
    } div_t;

    // one restoring division step: shift in next dividend bit, shift out quotient bit
    function automatic lane_t div_step(lane_t l, logic [DISP_BITS-1:0] d);
        logic [DISP_BITS:0] t;
        logic               qbit;
        lane_t              r;
        r = l;
        t = {l.rem, l.bits[Q_W-1]};
        if (t >= {1'b0, d})
        begin
            qbit  = 1'b1;
            r.rem = DISP_BITS'(t - {1'b0, d});
        end
        else
        begin
            qbit  = 1'b0;
            r.rem = t[DISP_BITS-1:0];
        end
        r.bits = {l.bits[Q_W-2:0], qbit};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/dpr_regs.sv @@
// dpr_regs: apb calibration register file for the reprojection pipeline
// depends on dpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpr_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dpr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [dpr_pkg::DATA_W-1:0] pwdata,
    output logic      [dpr_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output dpr_pkg::cfg_t                   cfg
);

    dpr_pkg::cfg_t    cfg_reg;
    dpr_pkg::cfg_t    cfg_next;
    dpr_pkg::reg_idx_t idx;
    logic             wr_en;

    assign idx    = dpr_pkg::reg_idx_t'(paddr[dpr_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                dpr_pkg::REG_FOCAL:
                    cfg_next.focal = pwdata[dpr_pkg::F_W-1:0];
                dpr_pkg::REG_BASELINE:
                begin
                    cfg_next.baseline     = $signed(pwdata[dpr_pkg::B_W-1:0]);
                    cfg_next.neg_baseline =
                        -dpr_pkg::NB_W'($signed(pwdata[dpr_pkg::B_W-1:0]));
                end
                dpr_pkg::REG_CENTER_X:
                    cfg_next.center_x = pwdata[dpr_pkg::C_W-1:0];
                dpr_pkg::REG_CENTER_Y:
                    cfg_next.center_y = pwdata[dpr_pkg::C_W-1:0];
                dpr_pkg::REG_Z_MIN:
                    cfg_next.z_min = pwdata[dpr_pkg::Z_W-1:0];
                dpr_pkg::REG_Z_MAX:
                    cfg_next.z_max = pwdata[dpr_pkg::Z_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            dpr_pkg::REG_FOCAL:    prdata = dpr_pkg::DATA_W'(cfg_reg.focal);
            dpr_pkg::REG_BASELINE: prdata = dpr_pkg::DATA_W'(cfg_reg.baseline);
            dpr_pkg::REG_CENTER_X: prdata = dpr_pkg::DATA_W'(cfg_reg.center_x);
            dpr_pkg::REG_CENTER_Y: prdata = dpr_pkg::DATA_W'(cfg_reg.center_y);
            dpr_pkg::REG_Z_MIN:    prdata = dpr_pkg::DATA_W'(cfg_reg.z_min);
            dpr_pkg::REG_Z_MAX:    prdata = dpr_pkg::DATA_W'(cfg_reg.z_max);
            default:               prdata = '0;
        endcase
    end

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal        <= dpr_pkg::FOCAL_RST;
            cfg_reg.baseline     <= dpr_pkg::BASELINE_RST;
            cfg_reg.neg_baseline <= dpr_pkg::NEG_BASE_RST;
            cfg_reg.center_x     <= dpr_pkg::CENTER_X_RST;
            cfg_reg.center_y     <= dpr_pkg::CENTER_Y_RST;
            cfg_reg.z_min        <= dpr_pkg::Z_MIN_RST;
            cfg_reg.z_max        <= dpr_pkg::Z_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/dpr_front.sv @@
// dpr_front: product stage and sign/magnitude stage that seed the divider
// depends on dpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpr_front (
    input  wire logic                           clk,
    input  wire logic [1:0]                     stage_en,
    input  wire logic [dpr_pkg::DISP_BITS-1:0]  disparity,
    input  wire logic [dpr_pkg::COORD_BITS-1:0] pixel_column,
    input  wire logic [dpr_pkg::COORD_BITS-1:0] pixel_row,
    input  wire dpr_pkg::cfg_t                  cfg,
    output dpr_pkg::div_t                       front_out
);

    logic [dpr_pkg::DISP_BITS-1:0]     d_reg;
    logic signed [dpr_pkg::P_W-1:0]    prod_reg [dpr_pkg::LANES];
    logic signed [dpr_pkg::P_W-1:0]    prod_next [dpr_pkg::LANES];
    logic signed [dpr_pkg::OFF_W-1:0]  off_x;
    logic signed [dpr_pkg::OFF_W-1:0]  off_y;
    logic signed [dpr_pkg::F_W:0]      focal_s;
    dpr_pkg::div_t                     seed_reg;
    dpr_pkg::div_t                     seed_next;

    // pixel offsets from the principal point, q4
    assign off_x = $signed(dpr_pkg::OFF_W'({pixel_column, 4'b0000}))
                 - $signed(dpr_pkg::OFF_W'(cfg.center_x));
    assign off_y = $signed(dpr_pkg::OFF_W'({pixel_row, 4'b0000}))
                 - $signed(dpr_pkg::OFF_W'(cfg.center_y));
    assign focal_s = $signed({1'b0, cfg.focal});

    // numerators: negated baseline times focal length and offsets
    always_comb
    begin
        prod_next[dpr_pkg::LANE_Z] = cfg.neg_baseline * focal_s;
        prod_next[dpr_pkg::LANE_X] = cfg.neg_baseline * off_x;
        prod_next[dpr_pkg::LANE_Y] = cfg.neg_baseline * off_y;
    end

    // magnitude over 16, overflow check against the divisor, initial remainder
    always_comb
    begin
        logic                          neg;
        logic [dpr_pkg::P_W-1:0]       mag;
        logic [dpr_pkg::NUM_W-1:0]     num;
        logic [dpr_pkg::CMP_W-1:0]     hi_ext;
        logic [dpr_pkg::CMP_W-1:0]     d_ext;
        seed_next.d = d_reg;
        d_ext       = dpr_pkg::CMP_W'(d_reg);
        for (int l = 0; l < dpr_pkg::LANES; l++)
        begin
            neg    = prod_reg[l][dpr_pkg::P_W-1];
            mag    = neg ? dpr_pkg::P_W'(-prod_reg[l]) : dpr_pkg::P_W'(prod_reg[l]);
            num    = mag[dpr_pkg::P_W-1:4];
            hi_ext = dpr_pkg::CMP_W'(num[dpr_pkg::NUM_W-1:dpr_pkg::Q_W]);
            seed_next.lane[l].neg  = neg;
            seed_next.lane[l].ovf  = (hi_ext >= d_ext);
            seed_next.lane[l].rem  = (hi_ext >= d_ext) ? '0
                                   : hi_ext[dpr_pkg::DISP_BITS-1:0];
            seed_next.lane[l].bits = num[dpr_pkg::Q_W-1:0];
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            d_reg <= disparity;
            for (int l = 0; l < dpr_pkg::LANES; l++)
            begin
                prod_reg[l] <= prod_next[l];
            end
        end
        if (stage_en[1])
        begin
            seed_reg <= seed_next;
        end
    end

    assign front_out = seed_reg;

endmodule

`default_nettype wire

@@ sv/dpr_div.sv @@
// dpr_div: pipelined restoring divider, three lanes sharing one divisor
// depends on dpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpr_div (
    input  wire logic [dpr_pkg::DIV_STAGES-1:0] stage_en,
    input  wire logic                           clk,
    input  wire dpr_pkg::div_t                  div_in,
    output dpr_pkg::div_t                       div_out
);

    dpr_pkg::div_t stage_reg  [dpr_pkg::DIV_STAGES];
    dpr_pkg::div_t stage_next [dpr_pkg::DIV_STAGES];

    // each stage resolves DIV_STEPS quotient bits per lane
    always_comb
    begin
        dpr_pkg::div_t cur;
        for (int k = 0; k < dpr_pkg::DIV_STAGES; k++)
        begin
            cur = (k == 0) ? div_in : stage_reg[(k == 0) ? 0 : k - 1];
            for (int l = 0; l < dpr_pkg::LANES; l++)
            begin
                for (int s = 0; s < dpr_pkg::DIV_STEPS; s++)
                begin
                    cur.lane[l] = dpr_pkg::div_step(cur.lane[l], cur.d);
                end
            end
            stage_next[k] = cur;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < dpr_pkg::DIV_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign div_out = stage_reg[dpr_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

@@ sv/dpr_back.sv @@
// dpr_back: depth window check, lateral saturation and output payload register
// depends on dpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpr_back (
    input  wire logic                           clk,
    input  wire logic                           load,
    input  wire dpr_pkg::div_t                  div_in,
    input  wire dpr_pkg::cfg_t                  cfg,
    output logic                                pass,
    output logic signed [dpr_pkg::XY_W-1:0]     point_x_um,
    output logic signed [dpr_pkg::XY_W-1:0]     point_y_um,
    output logic        [dpr_pkg::Z_W-1:0]      point_z_um
);

    logic signed [dpr_pkg::XY_W-1:0] x_reg;
    logic signed [dpr_pkg::XY_W-1:0] x_next;
    logic signed [dpr_pkg::XY_W-1:0] y_reg;
    logic signed [dpr_pkg::XY_W-1:0] y_next;
    logic        [dpr_pkg::Z_W-1:0]  z_reg;
    logic        [dpr_pkg::Z_W-1:0]  z_next;
    dpr_pkg::lane_t                  lz;

    // signed, saturated lateral coordinate from sign and quotient magnitude
    function automatic logic signed [dpr_pkg::XY_W-1:0] sat_xy(dpr_pkg::lane_t l);
        logic signed [dpr_pkg::XY_W-1:0] r;
        if (!l.neg)
        begin
            r = (l.ovf || l.bits > dpr_pkg::XY_POS_LIM)
              ? $signed(dpr_pkg::XY_POS_LIM) : $signed(l.bits);
        end
        else
        begin
            r = (l.ovf || l.bits > dpr_pkg::XY_NEG_LIM)
              ? $signed(dpr_pkg::XY_NEG_LIM) : $signed(dpr_pkg::XY_W'(-l.bits));
        end
        return r;
    endfunction

    assign lz = div_in.lane[dpr_pkg::LANE_Z];

    // depth must come from a nonzero disparity, not overflow, be nonnegative and lie inside [z_min, z_max)
    assign pass = (div_in.d != '0) && !lz.ovf
               && !(lz.neg && lz.bits != '0)
               && (lz.bits >= dpr_pkg::Q_W'(cfg.z_min))
               && (lz.bits <  dpr_pkg::Q_W'(cfg.z_max));

    assign x_next = sat_xy(div_in.lane[dpr_pkg::LANE_X]);
    assign y_next = sat_xy(div_in.lane[dpr_pkg::LANE_Y]);
    assign z_next = lz.bits[dpr_pkg::Z_W-1:0];

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign point_x_um = x_reg;
    assign point_y_um = y_reg;
    assign point_z_um = z_reg;

endmodule

`default_nettype wire

@@ sv/disparity_to_point_reprojection.sv @@
// stages from an accepted request to point_valid: multiply, magnitude,
// five divider stages of five quotient bits each, output register
// throughput: one request per cycle unless stalled; a stage holds only while the next
// is full and stalled, so bubbles are squeezed out; rejected requests leave no result
// reset: rst_n clears all valid bits at once and loads the default calibration
`timescale 1ns / 1ps
`default_nettype none

module disparity_to_point_reprojection (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dpr_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [dpr_pkg::DATA_W-1:0]     pwdata,
    output logic      [dpr_pkg::DATA_W-1:0]     prdata,
    output logic                                pready,
    input  wire logic                           pixel_valid,
    output logic                                pixel_stall,
    input  wire logic [dpr_pkg::DISP_BITS-1:0]  disparity,
    input  wire logic [dpr_pkg::COORD_BITS-1:0] pixel_column,
    input  wire logic [dpr_pkg::COORD_BITS-1:0] pixel_row,
    output logic                                point_valid,
    input  wire logic                           point_stall,
    output logic signed [dpr_pkg::XY_W-1:0]     point_x_um,
    output logic signed [dpr_pkg::XY_W-1:0]     point_y_um,
    output logic        [dpr_pkg::Z_W-1:0]      point_z_um
);

    localparam int LAST = dpr_pkg::NSTG - 1;

    dpr_pkg::cfg_t              cfg;
    dpr_pkg::div_t              front_out;
    dpr_pkg::div_t              div_out;
    logic                       pass;
    logic [dpr_pkg::NSTG-1:0]   valid_reg;
    logic [dpr_pkg::NSTG-1:0]   valid_next;
    logic [dpr_pkg::NSTG-1:0]   stage_en;

    dpr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpr_front u_front (
        .clk          (clk),
        .stage_en     (stage_en[1:0]),
        .disparity    (disparity),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .cfg          (cfg),
        .front_out    (front_out)
    );

    dpr_div u_div (
        .stage_en (stage_en[2 +: dpr_pkg::DIV_STAGES]),
        .clk      (clk),
        .div_in   (front_out),
        .div_out  (div_out)
    );

    dpr_back u_back (
        .clk        (clk),
        .load       (stage_en[LAST]),
        .div_in     (div_out),
        .cfg        (cfg),
        .pass       (pass),
        .point_x_um (point_x_um),
        .point_y_um (point_y_um),
        .point_z_um (point_z_um)
    );

    // a stage may load when it is empty or the stage after it moves on
    always_comb
    begin
        stage_en[LAST] = !valid_reg[LAST] || !point_stall;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k + 1];
        end
    end

    // valid bits travel with the data; the output stage keeps only passing points
    always_comb
    begin
        valid_next[0] = stage_en[0] ? pixel_valid : valid_reg[0];
        for (int k = 1; k < LAST; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_reg[k - 1] : valid_reg[k];
        end
        valid_next[LAST] = stage_en[LAST] ? (valid_reg[LAST - 1] && pass)
                                          : valid_reg[LAST];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pixel_stall = !stage_en[0];
    assign point_valid = valid_reg[LAST];

    // the input is held off only when every stage is full and the output is stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> ((&valid_reg) && point_stall))
        else $error("input stalled with room in the pipeline");

    // an accepted request occupies the first stage on the next cycle
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && !pixel_stall) |=> valid_reg[0])
        else $error("accepted request lost at the first stage");

    // a taken result with nothing behind it leaves the output empty
    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point_stall && !valid_reg[LAST - 1]) |=> !point_valid)
        else $error("result repeated after it was taken");

endmodule

`default_nettype wire
